// ===== rtl/wrge_pkg.sv =====
// Shared types, constants and a helper function for the water ripple grid engine.
`default_nettype none

package wrge_pkg;

    // Grid geometry.
    localparam int GRID_WIDTH  = 30;
    localparam int GRID_HEIGHT = 12;
    localparam int CELL_COUNT  = GRID_WIDTH * GRID_HEIGHT;

    // Derived widths.
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(GRID_WIDTH);
    localparam int ROW_W      = $clog2(GRID_HEIGHT);
    localparam int CELL_IDX_W = 9;
    localparam int H_W        = 8;
    localparam int CLAMP_W    = 7;
    localparam int CFG_W      = 8;
    localparam int CFG_IDX_W  = 1;

    // Neighborhood walk: nine taps, numbered row by row from the top-left corner.
    localparam int TAP_W    = 4;
    localparam int TAP_LAST = 8;

    // Accumulator holds the sum of nine signed bytes; the update value is narrower.
    localparam int SUM_W = 12;
    localparam int V_W   = 11;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CLAMP_LIMIT   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPLASH_HEIGHT = 1'd1;

    // Configuration reset values.
    localparam logic [CLAMP_W-1:0]      CLAMP_RESET  = 7'd80;
    localparam logic signed [H_W-1:0]   SPLASH_RESET = 8'sh7f;

    // Command codes.
    typedef enum logic [1:0] {
        CMD_SPLASH = 2'd0,
        CMD_FRAME  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_NONE   = 2'd3
    } t_cmd;

    // Input transaction payload.
    typedef struct packed {
        t_cmd                  cmd;
        logic [CELL_IDX_W-1:0] cell_index;
    } t_in_item;

    // Output transaction payload.
    typedef struct packed {
        logic signed [H_W-1:0] height;
        t_cmd                  done_cmd;
    } t_out_item;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_TAP,
        ST_SUB,
        ST_WRITE,
        ST_DONE
    } t_state;

    // Offset of a neighborhood tap from the top-left corner of the 3x3 window.
    function automatic logic [ADDR_W-1:0] tap_offset(input logic [TAP_W-1:0] tap);
        logic [ADDR_W-1:0] off;
        unique case (tap)
            4'd0:    off = ADDR_W'(0);
            4'd1:    off = ADDR_W'(1);
            4'd2:    off = ADDR_W'(2);
            4'd3:    off = ADDR_W'(GRID_WIDTH);
            4'd4:    off = ADDR_W'(GRID_WIDTH + 1);
            4'd5:    off = ADDR_W'(GRID_WIDTH + 2);
            4'd6:    off = ADDR_W'(2 * GRID_WIDTH);
            4'd7:    off = ADDR_W'(2 * GRID_WIDTH + 1);
            4'd8:    off = ADDR_W'(2 * GRID_WIDTH + 2);
            default: off = ADDR_W'(0);
        endcase
        return off;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/wrge_page_ram.sv =====
// Generic single-write, single-read RAM with registered read data, one height page.
`default_nettype none

module wrge_page_ram #(
    parameter int DEPTH  = 360,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = 9
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port; the data register holds between reads.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/water_ripple_grid_engine.sv =====
// Top level of the water ripple grid engine: sequencer, shared accumulator and page RAMs.
//
//  Channel | Direction | Handshake                  | Payload
//  --------+-----------+----------------------------+-----------------------------------
//  in      | input     | i_in_valid / o_in_stall    | i_in_data  (cmd, cell_index)
//  out     | output    | o_out_valid / i_out_stall  | o_out_data (height, done_cmd)
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// A splash, read or unused command passes through the execute and done states before its
// result is loaded. A frame walks every interior cell in turn: each interior cell reads the
// nine cells of its 3x3 window one per cycle through the single read port of the current page
// into one shared accumulator, then passes through the subtract and write states for the update.
// After reset a clearing pass writes zero to every cell of both pages;
// no transaction is accepted meanwhile, but configuration writes are taken.
// The next command is accepted while a result waits in the output register; a finished
// result is held back only if that register is still stalled.
`default_nettype none

module water_ripple_grid_engine (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  i_in_valid,
    output logic                                       o_in_stall,
    input  wire wrge_pkg::t_in_item                    i_in_data,
    output logic                                       o_out_valid,
    input  wire logic                                  i_out_stall,
    output wrge_pkg::t_out_item                        o_out_data,
    input  wire logic                                  i_cfg_we,
    input  wire logic [wrge_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [wrge_pkg::CFG_W-1:0]            i_cfg_data
);

    localparam int ADDR_W = wrge_pkg::ADDR_W;
    localparam int COL_W  = wrge_pkg::COL_W;
    localparam int ROW_W  = wrge_pkg::ROW_W;
    localparam int TAP_W  = wrge_pkg::TAP_W;
    localparam int SUM_W  = wrge_pkg::SUM_W;
    localparam int V_W    = wrge_pkg::V_W;
    localparam int H_W    = wrge_pkg::H_W;

    // Control and configuration registers.
    wrge_pkg::t_state                     r_state;
    wrge_pkg::t_state                     n_state;
    logic                                 r_cur;
    logic [ADDR_W-1:0]                    r_clr;
    logic [wrge_pkg::CLAMP_W-1:0]         r_clamp_limit;
    logic signed [H_W-1:0]                r_splash_height;
    logic                                 r_out_valid;

    // Command and frame-walk registers.
    wrge_pkg::t_in_item                   r_item;
    logic [COL_W-1:0]                     r_col;
    logic [ROW_W-1:0]                     r_row;
    logic [ADDR_W-1:0]                    r_corner;
    logic [TAP_W-1:0]                     r_tap;
    logic signed [SUM_W-1:0]              r_sum;
    logic signed [V_W-1:0]                r_v;
    wrge_pkg::t_out_item                  r_out;

    // Handshake and decode.
    logic                                 in_accept;
    logic                                 out_free;
    logic                                 cell_ok;
    logic [ADDR_W-1:0]                    cell_addr;
    logic                                 last_col;
    logic                                 last_row;
    logic                                 last_cell;
    logic [ADDR_W-1:0]                    center;
    logic [ADDR_W-1:0]                    tap_addr;

    // Page access requests in current/other terms.
    logic                                 rd_cur_en;
    logic [ADDR_W-1:0]                    rd_cur_addr;
    logic                                 rd_oth_en;
    logic [ADDR_W-1:0]                    rd_oth_addr;
    logic                                 wr_cur_en;
    logic                                 wr_oth_en;
    logic [ADDR_W-1:0]                    wr_addr;
    logic [H_W-1:0]                       wr_data;

    // Physical page ports.
    logic                                 we0;
    logic                                 we1;
    logic                                 re0;
    logic                                 re1;
    logic [ADDR_W-1:0]                    raddr0;
    logic [ADDR_W-1:0]                    raddr1;
    logic [H_W-1:0]                       rdata0;
    logic [H_W-1:0]                       rdata1;
    logic signed [H_W-1:0]                rdata_cur;
    logic signed [H_W-1:0]                rdata_oth;

    // Arithmetic.
    logic signed [SUM_W-1:0]              sum_full;
    logic signed [SUM_W-1:0]              sum_shr;
    logic signed [V_W-1:0]                v_next;
    logic signed [V_W-1:0]                w_val;
    logic signed [V_W-1:0]                lim;
    logic signed [V_W-1:0]                neg_lim;
    logic signed [V_W-1:0]                clamp_val;
    logic [H_W-1:0]                       new_h;

    // Handshake.
    assign o_in_stall  = (r_state != wrge_pkg::ST_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Cell decode for splash and read.
    assign cell_ok   = (32'(r_item.cell_index) < 32'(wrge_pkg::CELL_COUNT));
    assign cell_addr = ADDR_W'(r_item.cell_index);

    // Frame walk position.
    assign last_col  = (r_col == COL_W'(wrge_pkg::GRID_WIDTH - 2));
    assign last_row  = (r_row == ROW_W'(wrge_pkg::GRID_HEIGHT - 2));
    assign last_cell = last_col && last_row;
    assign center    = r_corner + ADDR_W'(wrge_pkg::GRID_WIDTH + 1);
    assign tap_addr  = r_corner + wrge_pkg::tap_offset(r_tap);

    // Current and other page read data.
    assign rdata_cur = r_cur ? rdata1 : rdata0;
    assign rdata_oth = r_cur ? rdata0 : rdata1;

    // Shared accumulator plus the two update steps.
    assign sum_full = r_sum + SUM_W'(rdata_cur);
    assign sum_shr  = sum_full >>> 2;
    assign v_next   = V_W'(sum_shr) - V_W'(rdata_oth);
    assign w_val    = r_v - (r_v >>> 3);
    assign lim      = V_W'(signed'({1'b0, r_clamp_limit}));
    assign neg_lim  = -lim;

    // Symmetric saturation.
    always_comb begin
        priority if (w_val < neg_lim) begin
            clamp_val = neg_lim;
        end else if (w_val > lim) begin
            clamp_val = lim;
        end else begin
            clamp_val = w_val;
        end
    end

    assign new_h = H_W'(clamp_val);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wrge_pkg::ST_CLEAR: begin
                if (r_clr == ADDR_W'(wrge_pkg::CELL_COUNT - 1)) begin
                    n_state = wrge_pkg::ST_IDLE;
                end
            end
            wrge_pkg::ST_IDLE: begin
                if (in_accept) begin
                    n_state = wrge_pkg::ST_EXEC;
                end
            end
            wrge_pkg::ST_EXEC: begin
                if (r_item.cmd == wrge_pkg::CMD_FRAME) begin
                    n_state = wrge_pkg::ST_TAP;
                end else begin
                    n_state = wrge_pkg::ST_DONE;
                end
            end
            wrge_pkg::ST_TAP: begin
                if (r_tap == TAP_W'(wrge_pkg::TAP_LAST)) begin
                    n_state = wrge_pkg::ST_SUB;
                end
            end
            wrge_pkg::ST_SUB: begin
                n_state = wrge_pkg::ST_WRITE;
            end
            wrge_pkg::ST_WRITE: begin
                if (last_cell) begin
                    n_state = wrge_pkg::ST_DONE;
                end else begin
                    n_state = wrge_pkg::ST_TAP;
                end
            end
            wrge_pkg::ST_DONE: begin
                if (out_free) begin
                    n_state = wrge_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // Page access requests per state.
    always_comb begin
        rd_cur_en   = 1'b0;
        rd_cur_addr = tap_addr;
        rd_oth_en   = 1'b0;
        rd_oth_addr = center;
        wr_cur_en   = 1'b0;
        wr_oth_en   = 1'b0;
        wr_addr     = center;
        wr_data     = new_h;
        unique case (r_state)
            wrge_pkg::ST_CLEAR: begin
                wr_cur_en = 1'b1;
                wr_oth_en = 1'b1;
                wr_addr   = r_clr;
                wr_data   = '0;
            end
            wrge_pkg::ST_EXEC: begin
                unique case (r_item.cmd)
                    wrge_pkg::CMD_SPLASH: begin
                        wr_cur_en = cell_ok;
                        wr_addr   = cell_addr;
                        wr_data   = r_splash_height;
                    end
                    wrge_pkg::CMD_READ: begin
                        rd_cur_en   = cell_ok;
                        rd_cur_addr = cell_addr;
                    end
                    wrge_pkg::CMD_FRAME,
                    wrge_pkg::CMD_NONE: begin
                        rd_cur_en = 1'b0;
                    end
                endcase
            end
            wrge_pkg::ST_TAP: begin
                rd_cur_en = 1'b1;
                rd_oth_en = (r_tap == '0);
            end
            wrge_pkg::ST_WRITE: begin
                wr_oth_en = 1'b1;
            end
            wrge_pkg::ST_IDLE,
            wrge_pkg::ST_SUB,
            wrge_pkg::ST_DONE: begin
                rd_cur_en = 1'b0;
            end
        endcase
    end

    // Map current/other requests onto the two physical pages.
    assign we0    = r_cur ? wr_oth_en : wr_cur_en;
    assign we1    = r_cur ? wr_cur_en : wr_oth_en;
    assign re0    = r_cur ? rd_oth_en : rd_cur_en;
    assign re1    = r_cur ? rd_cur_en : rd_oth_en;
    assign raddr0 = r_cur ? rd_oth_addr : rd_cur_addr;
    assign raddr1 = r_cur ? rd_cur_addr : rd_oth_addr;

    wrge_page_ram #(
        .DEPTH  (wrge_pkg::CELL_COUNT),
        .WIDTH  (H_W),
        .ADDR_W (ADDR_W)
    ) u_page0 (
        .i_clk   (i_clk),
        .i_we    (we0),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (re0),
        .i_raddr (raddr0),
        .o_rdata (rdata0)
    );

    wrge_page_ram #(
        .DEPTH  (wrge_pkg::CELL_COUNT),
        .WIDTH  (H_W),
        .ADDR_W (ADDR_W)
    ) u_page1 (
        .i_clk   (i_clk),
        .i_we    (we1),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (re1),
        .i_raddr (raddr1),
        .o_rdata (rdata1)
    );

    // Control state, configuration and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= wrge_pkg::ST_CLEAR;
            r_cur           <= 1'b0;
            r_clr           <= '0;
            r_clamp_limit   <= wrge_pkg::CLAMP_RESET;
            r_splash_height <= wrge_pkg::SPLASH_RESET;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == wrge_pkg::ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    wrge_pkg::CFG_CLAMP_LIMIT:   r_clamp_limit   <= i_cfg_data[wrge_pkg::CLAMP_W-1:0];
                    wrge_pkg::CFG_SPLASH_HEIGHT: r_splash_height <= i_cfg_data;
                endcase
            end
            if (r_state == wrge_pkg::ST_WRITE && last_cell) begin
                r_cur <= ~r_cur;
            end
            if (r_state == wrge_pkg::ST_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command latch, frame walk and accumulator.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item   <= i_in_data;
            r_col    <= COL_W'(1);
            r_row    <= ROW_W'(1);
            r_corner <= '0;
            r_tap    <= '0;
        end
        if (r_state == wrge_pkg::ST_TAP) begin
            r_tap <= r_tap + 1'b1;
            if (r_tap == '0) begin
                r_sum <= '0;
            end else begin
                r_sum <= sum_full;
            end
        end
        if (r_state == wrge_pkg::ST_SUB) begin
            r_v <= v_next;
        end
        if (r_state == wrge_pkg::ST_WRITE) begin
            r_tap <= '0;
            if (last_col) begin
                r_col    <= COL_W'(1);
                r_row    <= r_row + 1'b1;
                r_corner <= r_corner + ADDR_W'(3);
            end else begin
                r_col    <= r_col + 1'b1;
                r_corner <= r_corner + 1'b1;
            end
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (r_state == wrge_pkg::ST_DONE && out_free) begin
            r_out.done_cmd <= r_item.cmd;
            if (r_item.cmd == wrge_pkg::CMD_READ && cell_ok) begin
                r_out.height <= rdata_cur;
            end else begin
                r_out.height <= '0;
            end
        end
    end

    // An accepted transaction always starts execution on the next cycle.
    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == wrge_pkg::ST_EXEC))
        else $error("accepted transaction did not enter execution");

    // Pages swap only after the last interior cell of a frame is written.
    a_swap_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_cur) |-> ($past(r_state) == wrge_pkg::ST_WRITE && $past(last_cell)))
        else $error("page swap outside the end of a frame");

    // A new result only appears after the sequencer finished a command.
    a_result_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == wrge_pkg::ST_DONE))
        else $error("result loaded without a finished command");

    // The neighborhood walk stays within nine taps.
    a_tap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wrge_pkg::ST_TAP) |-> (r_tap <= TAP_W'(wrge_pkg::TAP_LAST)))
        else $error("tap counter out of range");

    // The frame walk only visits interior cells.
    a_interior: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == wrge_pkg::ST_TAP) |->
            (r_col >= COL_W'(1) && r_col <= COL_W'(wrge_pkg::GRID_WIDTH - 2) &&
             r_row >= ROW_W'(1) && r_row <= ROW_W'(wrge_pkg::GRID_HEIGHT - 2)))
        else $error("frame walk left the interior");

endmodule

`default_nettype wire
